[hdl/xsf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsf_pkg: shared types and constants of the XOR sprite frame buffer
// Screen geometry, item codes, queue entry format and the column and row wrap tables.
// ----------------------------------------------------------------------------
package xsf_pkg;

  localparam int SCREEN_WIDTH  = 64;  // 8..64
  localparam int SCREEN_HEIGHT = 32;  // 8..64

  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
  localparam int LINE_W = 64;         // scan-out port width
  localparam int QUEUE_DEPTH = 2;

  // Codes of the mode field
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_DRAW  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Classified operation handed from the front to the back
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_DRAW,
    OP_READ,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [ROW_W-1:0]        row;    // target buffer row, already wrapped
    logic [SCREEN_WIDTH-1:0] mask;   // XOR mask, bit c = column c
    logic                    first;  // row index zero: restart collision
    logic                    last;
  } cmd_t;

  // origin_x modulo SCREEN_WIDTH for every 8-bit value, built at elaboration
  function automatic logic [256*COL_W-1:0] build_col_mod();
    logic [256*COL_W-1:0] tbl;
    tbl = '0;
    for (int i = 0; i < 256; i++) begin
      tbl[i*COL_W +: COL_W] = COL_W'(i % SCREEN_WIDTH);
    end
    return tbl;
  endfunction

  // origin_y modulo SCREEN_HEIGHT, same form
  function automatic logic [256*ROW_W-1:0] build_row_mod();
    logic [256*ROW_W-1:0] tbl;
    tbl = '0;
    for (int i = 0; i < 256; i++) begin
      tbl[i*ROW_W +: ROW_W] = ROW_W'(i % SCREEN_HEIGHT);
    end
    return tbl;
  endfunction

  localparam logic [256*COL_W-1:0] COL_MOD = build_col_mod();
  localparam logic [256*ROW_W-1:0] ROW_MOD = build_row_mod();

endpackage

[hdl/xsf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsf_if: item and result channels of the XOR sprite frame buffer
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface xsf_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] origin_x;
  logic [7:0] origin_y;
  logic [3:0] row_index;
  logic [7:0] row_bits;
  logic       last_row;

  modport source (
    output valid, mode, origin_x, origin_y, row_index, row_bits, last_row,
    input  ready
  );
  modport sink (
    input  valid, mode, origin_x, origin_y, row_index, row_bits, last_row,
    output ready
  );
endinterface

interface xsf_result_if;
  logic        valid;
  logic        ready;
  logic        collision;
  logic        sprite_done;
  logic [63:0] line_pixels;

  modport source (
    output valid, collision, sprite_done, line_pixels,
    input  ready
  );
  modport sink (
    input  valid, collision, sprite_done, line_pixels,
    output ready
  );
endinterface

[hdl/xsf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsf_front: item intake and classification
// Decodes the mode, wraps the target row and builds the column XOR mask.
// ----------------------------------------------------------------------------
module xsf_front (
  xsf_item_if.sink     item_i,
  input  logic         full_i,
  output logic         push_o,
  output xsf_pkg::cmd_t cmd_o
);

  localparam int RS_W = 9;

  logic [xsf_pkg::COL_W-1:0]   ox_mod;
  logic [xsf_pkg::COL_W:0]     col_sum [8];
  logic [xsf_pkg::COL_W-1:0]   col     [8];
  logic [xsf_pkg::ROW_W-1:0]   oy_mod;
  logic [RS_W-1:0]             idx_mod;
  logic [RS_W-1:0]             row_sum;
  logic [RS_W-1:0]             row_wrap;
  logic [xsf_pkg::SCREEN_WIDTH-1:0] mask;

  assign item_i.ready = !full_i;
  assign push_o       = item_i.valid && !full_i;

  assign ox_mod = xsf_pkg::COL_MOD[item_i.origin_x*xsf_pkg::COL_W +: xsf_pkg::COL_W];
  assign oy_mod = xsf_pkg::ROW_MOD[item_i.origin_y*xsf_pkg::ROW_W +: xsf_pkg::ROW_W];

  // sum stays below twice the width, so one subtract wraps it
  always_comb begin
    mask = '0;
    for (int j = 0; j < 8; j++) begin
      col_sum[j] = {1'b0, ox_mod} + (xsf_pkg::COL_W+1)'(j);
      if (col_sum[j] >= (xsf_pkg::COL_W+1)'(xsf_pkg::SCREEN_WIDTH)) begin
        col_sum[j] = col_sum[j] - (xsf_pkg::COL_W+1)'(xsf_pkg::SCREEN_WIDTH);
      end
      col[j] = col_sum[j][xsf_pkg::COL_W-1:0];
      if (item_i.row_bits[7-j]) begin
        mask[col[j]] = 1'b1;
      end
    end
  end

  always_comb begin
    idx_mod = RS_W'(item_i.row_index);
    if (idx_mod >= RS_W'(xsf_pkg::SCREEN_HEIGHT)) begin
      idx_mod = idx_mod - RS_W'(xsf_pkg::SCREEN_HEIGHT);
    end
    row_sum  = RS_W'(oy_mod) + idx_mod;
    row_wrap = row_sum;
    if (row_sum >= RS_W'(xsf_pkg::SCREEN_HEIGHT)) begin
      row_wrap = row_sum - RS_W'(xsf_pkg::SCREEN_HEIGHT);
    end
  end

  always_comb begin
    cmd_o.row   = row_wrap[xsf_pkg::ROW_W-1:0];
    cmd_o.mask  = mask;
    cmd_o.first = (item_i.row_index == 4'd0);
    cmd_o.last  = item_i.last_row;
    unique case (item_i.mode)
      xsf_pkg::MODE_CLEAR: cmd_o.op = xsf_pkg::OP_CLEAR;
      xsf_pkg::MODE_DRAW:  cmd_o.op = xsf_pkg::OP_DRAW;
      xsf_pkg::MODE_READ: begin
        cmd_o.op  = xsf_pkg::OP_READ;
        cmd_o.row = oy_mod;
      end
      default:             cmd_o.op = xsf_pkg::OP_NOP;
    endcase
  end

endmodule

[hdl/xsf_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsf_queue: short command queue between front and back
// Register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module xsf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  xsf_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output xsf_pkg::cmd_t head_o
);

  localparam int PTR_W = $clog2(xsf_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(xsf_pkg::QUEUE_DEPTH + 1);

  xsf_pkg::cmd_t    slot_q [xsf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o       = (count_q == CNT_W'(xsf_pkg::QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(xsf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(xsf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hdl/xsf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsf_back: frame buffer execution unit
// Row memory with per-row valid flags, XOR read-modify-write, output register.
// ----------------------------------------------------------------------------
module xsf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  xsf_pkg::cmd_t  head_i,
  output logic           pop_o,
  xsf_result_if.source   result_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                           state_q;
  xsf_pkg::cmd_t                    cur_q;
  logic                             flag_q;
  logic [xsf_pkg::SCREEN_HEIGHT-1:0] row_valid_q;
  logic                             res_valid_q;
  logic                             res_collision_q;
  logic                             res_done_q;
  logic [xsf_pkg::LINE_W-1:0]       res_pixels_q;

  logic [xsf_pkg::SCREEN_WIDTH-1:0] mem_q [xsf_pkg::SCREEN_HEIGHT];
  logic [xsf_pkg::SCREEN_WIDTH-1:0] rd_data_q;

  logic                             out_free;
  logic                             head_needs_mem;
  logic                             rd_en;
  logic                             wr_en;
  logic [xsf_pkg::SCREEN_WIDTH-1:0] line;
  logic [xsf_pkg::SCREEN_WIDTH-1:0] new_line;
  logic                             hit;
  logic                             flag_next;

  assign out_free       = !res_valid_q || result_o.ready;
  assign head_needs_mem = (head_i.op == xsf_pkg::OP_DRAW) || (head_i.op == xsf_pkg::OP_READ);
  assign pop_o          = (state_q == ST_IDLE) && head_valid_i && (head_needs_mem || out_free);
  assign rd_en          = pop_o && head_needs_mem;
  assign wr_en          = (state_q == ST_EXEC) && out_free && (cur_q.op == xsf_pkg::OP_DRAW);

  // never-written or cleared rows read as dark
  assign line      = row_valid_q[cur_q.row] ? rd_data_q : '0;
  assign hit       = |(line & cur_q.mask);
  assign new_line  = line ^ cur_q.mask;
  assign flag_next = (cur_q.first ? 1'b0 : flag_q) | hit;

  assign result_o.valid       = res_valid_q;
  assign result_o.collision   = res_collision_q;
  assign result_o.sprite_done = res_done_q;
  assign result_o.line_pixels = res_pixels_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[head_i.row];
    end
    if (wr_en) begin
      mem_q[cur_q.row] <= new_line;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      cur_q           <= '0;
      flag_q          <= 1'b0;
      row_valid_q     <= '0;
      res_valid_q     <= 1'b0;
      res_collision_q <= 1'b0;
      res_done_q      <= 1'b0;
      res_pixels_q    <= '0;
    end else begin
      if (res_valid_q && result_o.ready) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            if (head_needs_mem) begin
              cur_q   <= head_i;
              state_q <= ST_EXEC;
            end else begin
              res_valid_q     <= 1'b1;
              res_collision_q <= flag_q;
              res_done_q      <= 1'b0;
              res_pixels_q    <= '0;
              if (head_i.op == xsf_pkg::OP_CLEAR) begin
                row_valid_q <= '0;
              end
            end
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            res_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
            if (cur_q.op == xsf_pkg::OP_DRAW) begin
              flag_q                 <= flag_next;
              row_valid_q[cur_q.row] <= 1'b1;
              res_collision_q        <= flag_next;
              res_done_q             <= cur_q.last;
              res_pixels_q           <= '0;
            end else begin
              res_collision_q <= flag_q;
              res_done_q      <= 1'b0;
              res_pixels_q    <= xsf_pkg::LINE_W'(line);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[hdl/xor_sprite_framebuffer.sv]
`timescale 1ns / 1ps
// Path: draw and read pass the queue register, the back unit's memory read
//   register and the output register; clear and unused mode skip the memory read.
// The back unit takes no new draw or read until the last is through its memory
//   read and, for a draw, its XOR write-back; output back-pressure stalls it.
// Reset: asynchronous; all per-row valid flags drop at once, so the whole
//   frame reads dark right after reset with no clearing pass.
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer: monochrome XOR sprite frame buffer
// Clear, draw one 8-pixel sprite row with wrap and collision, or scan out a row.
// ----------------------------------------------------------------------------
module xor_sprite_framebuffer (
  input  logic         clk_i,
  input  logic         rst_ni,
  xsf_item_if.sink     item_i,
  xsf_result_if.source result_o
);

  // Front: decode and wrap coordinates, build the XOR mask.
  // Queue: two entries, so the front keeps taking items while the back
  //   waits on the output register.
  // Back: row memory plus valid flags; a clear just drops the flags.

  xsf_pkg::cmd_t front_cmd;
  xsf_pkg::cmd_t head_cmd;
  logic          push;
  logic          q_full;
  logic          head_valid;
  logic          pop;

  xsf_front u_front (
    .item_i (item_i),
    .full_i (q_full),
    .push_o (push),
    .cmd_o  (front_cmd)
  );

  xsf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (front_cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_cmd)
  );

  xsf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .result_o     (result_o)
  );

  // a transfer in always leaves something queued for the back unit
  a_push_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> head_valid)
    else $error("transfer in did not reach the queue");

  // the back never pops an empty queue
  a_pop_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("pop from empty queue");

  // only draw results finish a sprite, and they carry no pixels
  a_done_no_pixels : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.sprite_done) |-> (result_o.line_pixels == '0))
    else $error("sprite_done with scan-out pixels");

  // columns past the screen width stay dark
  a_row_width : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> ((result_o.line_pixels >> xsf_pkg::SCREEN_WIDTH) == '0))
    else $error("pixel beyond screen width");

endmodule
